@@ rtl/core/bfhp_pkg.sv @@
// ----------------------------------------------------------------------------
// bfhp_pkg
// Shared types and constants of the bit file header parser.
// ----------------------------------------------------------------------------
package bfhp_pkg;

    // limit on header bytes consumed before the header is declared invalid
    localparam int unsigned HEADER_LIMIT = 65536;

    localparam int unsigned POS_W    = 17;
    localparam int unsigned CNT_W    = 16;
    localparam int unsigned ACC_W    = 32;
    localparam int unsigned CFG_W    = 8;
    localparam int unsigned CFG_IDX_W = 1;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_EVEN_MAGIC = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ODD_MAGIC  = 1'd1;

    // status codes
    localparam logic [1:0] ST_PARSING = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;

    // field tags
    localparam logic [2:0] TAG_NONE = 3'd0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]       status;
        logic [2:0]       field_tag;
        logic [7:0]       string_byte;
        logic [POS_W-1:0] header_length;
        logic [ACC_W-1:0] bitstream_length;
    } t_out_beat;

endpackage

@@ rtl/core/bfhp_in_if.sv @@
// ----------------------------------------------------------------------------
// bfhp_in_if
// Valid/ready channel carrying header bytes into the parser.
// ----------------------------------------------------------------------------
interface bfhp_in_if;
    logic              valid;
    logic              ready;
    bfhp_pkg::t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/bfhp_out_if.sv @@
// ----------------------------------------------------------------------------
// bfhp_out_if
// Valid/ready channel carrying parser results.
// ----------------------------------------------------------------------------
interface bfhp_out_if;
    logic                valid;
    logic                ready;
    bfhp_pkg::t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/bit_file_header_parser_core.sv @@
// ----------------------------------------------------------------------------
// bit_file_header_parser_core
// Byte-serial parser for the header of a configuration bit file: magic
// length and pattern, marker half word, keyed string fields a to d, key e
// and the 32-bit bitstream length. String bytes leave tagged by field.
// ----------------------------------------------------------------------------
//  channel    dir  beat contents
//  i_byte_ch  in   data_byte, restart
//  o_res_ch   out  status, field_tag, string_byte, header_length,
//                  bitstream_length
//  i_cfg_*    in   register write: even / odd magic value
//
//  one result beat per header byte, one byte accepted per cycle while the sink is not stalling
//  the result of each accepted byte is registered in the result register
//  the parse state updates in the accept cycle; the result register holds
//  while the sink stalls and a new byte is taken as soon as it drains
//  synchronous active-low reset: parser cleared, magic values 0x0f / 0xf0
// ----------------------------------------------------------------------------
module bit_file_header_parser_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    bfhp_in_if.sink                           i_byte_ch,
    bfhp_out_if.source                        o_res_ch,
    input  logic                              i_cfg_we,
    input  logic [bfhp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bfhp_pkg::CFG_W-1:0]        i_cfg_data
);

    // parse phases; field phases are FIELD0 + 4*field + sub
    localparam logic [4:0] PH_MLEN_HI = 5'd0;
    localparam logic [4:0] PH_MLEN_LO = 5'd1;
    localparam logic [4:0] PH_MAGIC   = 5'd2;
    localparam logic [4:0] PH_TERM    = 5'd3;
    localparam logic [4:0] PH_ONE_HI  = 5'd4;
    localparam logic [4:0] PH_ONE_LO  = 5'd5;
    localparam logic [4:0] PH_FIELD0  = 5'd6;
    localparam logic [4:0] PH_KEY_E   = 5'd22;
    localparam logic [4:0] PH_BITLEN  = 5'd23;
    localparam logic [4:0] PH_DONE    = 5'd24;

    localparam logic [1:0] SUB_KEY    = 2'd0;
    localparam logic [1:0] SUB_LEN_HI = 2'd1;
    localparam logic [1:0] SUB_LEN_LO = 2'd2;

    localparam logic [7:0] KEY_A    = 8'h61;
    localparam logic [7:0] KEY_E    = 8'h65;
    localparam logic [1:0] LAST_FIELD = 2'd3;

    localparam int unsigned POS_W = bfhp_pkg::POS_W;
    localparam int unsigned CNT_W = bfhp_pkg::CNT_W;
    localparam int unsigned ACC_W = bfhp_pkg::ACC_W;
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(bfhp_pkg::HEADER_LIMIT);

    // configuration
    logic [7:0] r_even_magic;
    logic [7:0] r_odd_magic;

    // parse state
    logic [4:0]       r_phase,  n_phase;
    logic [CNT_W-1:0] r_fcount, n_fcount;
    logic [CNT_W-1:0] r_flen,   n_flen;
    logic [POS_W-1:0] r_pos,    n_pos;
    logic [ACC_W-1:0] r_acc,    n_acc;
    logic [1:0]       r_status, n_status;

    // result register
    logic                r_out_valid;
    bfhp_pkg::t_out_beat r_out, n_out;

    // state seen by this byte, after an optional restart
    logic [4:0]       c_phase;
    logic [CNT_W-1:0] c_fcount;
    logic [CNT_W-1:0] c_flen;
    logic [POS_W-1:0] c_pos;
    logic [ACC_W-1:0] c_acc;
    logic [1:0]       c_status;

    logic             accept;
    logic [7:0]       b;
    logic [4:0]       rel;
    logic [1:0]       fld;
    logic [1:0]       sub;
    logic [15:0]      half;
    logic [CNT_W:0]   cnt_inc;
    logic [7:0]       want;
    logic [2:0]       tag;
    logic [7:0]       sbyte;
    logic             fail;

    assign i_byte_ch.ready = !r_out_valid || o_res_ch.ready;
    assign accept          = i_byte_ch.valid && i_byte_ch.ready;
    assign b               = i_byte_ch.data.data_byte;

    assign o_res_ch.valid = r_out_valid;
    assign o_res_ch.data  = r_out;

    always_comb begin
        if (i_byte_ch.data.restart) begin
            c_phase  = PH_MLEN_HI;
            c_fcount = '0;
            c_flen   = '0;
            c_pos    = '0;
            c_acc    = '0;
            c_status = bfhp_pkg::ST_PARSING;
        end else begin
            c_phase  = r_phase;
            c_fcount = r_fcount;
            c_flen   = r_flen;
            c_pos    = r_pos;
            c_acc    = r_acc;
            c_status = r_status;
        end
    end

    assign rel     = c_phase - PH_FIELD0;
    assign fld     = rel[3:2];
    assign sub     = rel[1:0];
    assign half    = {c_acc[7:0], b};
    assign cnt_inc = {1'b0, c_fcount} + (CNT_W+1)'(1);
    assign want    = c_fcount[0] ? r_odd_magic : r_even_magic;

    // one parse step
    always_comb begin
        n_phase  = c_phase;
        n_fcount = c_fcount;
        n_flen   = c_flen;
        n_pos    = c_pos;
        n_acc    = c_acc;
        n_status = c_status;
        tag      = bfhp_pkg::TAG_NONE;
        sbyte    = 8'd0;
        fail     = 1'b0;

        if (c_status == bfhp_pkg::ST_PARSING) begin
            if (c_pos >= POS_LIMIT) begin
                fail = 1'b1;
            end else begin
                n_pos = c_pos + POS_W'(1);
                if (c_phase == PH_MLEN_HI) begin
                    n_acc   = ACC_W'(b);
                    n_phase = PH_MLEN_LO;
                end else if (c_phase == PH_MLEN_LO) begin
                    if (half == 16'd0) begin
                        fail = 1'b1;
                    end else if (half == 16'd1) begin
                        n_phase = PH_TERM;
                    end else begin
                        n_flen   = half - 16'd1;
                        n_fcount = '0;
                        n_phase  = PH_MAGIC;
                    end
                end else if (c_phase == PH_MAGIC) begin
                    if (b != want) begin
                        fail = 1'b1;
                    end else begin
                        n_fcount = cnt_inc[CNT_W-1:0];
                        if (cnt_inc[CNT_W-1:0] >= c_flen) begin
                            n_phase = PH_TERM;
                        end
                    end
                end else if (c_phase == PH_TERM) begin
                    n_phase = PH_ONE_HI;
                end else if (c_phase == PH_ONE_HI) begin
                    n_acc   = ACC_W'(b);
                    n_phase = PH_ONE_LO;
                end else if (c_phase == PH_ONE_LO) begin
                    if (half != 16'd1) begin
                        fail = 1'b1;
                    end else begin
                        n_phase = PH_FIELD0;
                    end
                end else if (c_phase >= PH_FIELD0 && c_phase < PH_KEY_E) begin
                    case (sub)
                        SUB_KEY: begin
                            if (b != KEY_A + 8'(fld)) begin
                                fail = 1'b1;
                            end else begin
                                n_phase = c_phase + 5'd1;
                            end
                        end
                        SUB_LEN_HI: begin
                            n_acc   = ACC_W'(b);
                            n_phase = c_phase + 5'd1;
                        end
                        SUB_LEN_LO: begin
                            n_flen   = half;
                            n_fcount = '0;
                            if (half == 16'd0) begin
                                fail = 1'b1;
                            end else begin
                                n_phase = c_phase + 5'd1;
                            end
                        end
                        default: begin
                            // string byte, tagged whether or not it passes
                            tag   = 3'(fld) + 3'd1;
                            sbyte = b;
                            if (cnt_inc >= {1'b0, c_flen}) begin
                                if (b != 8'd0) begin
                                    fail = 1'b1;
                                end else if (fld == LAST_FIELD) begin
                                    n_phase = PH_KEY_E;
                                end else begin
                                    n_phase = c_phase + 5'd1;
                                end
                            end else begin
                                n_fcount = cnt_inc[CNT_W-1:0];
                            end
                        end
                    endcase
                end else if (c_phase == PH_KEY_E) begin
                    if (b != KEY_E) begin
                        fail = 1'b1;
                    end else begin
                        n_acc    = '0;
                        n_fcount = '0;
                        n_phase  = PH_BITLEN;
                    end
                end else if (c_phase == PH_BITLEN) begin
                    n_acc    = {c_acc[ACC_W-9:0], b};
                    n_fcount = cnt_inc[CNT_W-1:0];
                    if (cnt_inc[CNT_W-1:0] >= CNT_W'(4)) begin
                        n_status = bfhp_pkg::ST_DONE;
                        n_phase  = PH_DONE;
                    end
                end else begin
                    fail = 1'b1;
                end
            end
        end

        if (fail) begin
            n_status = bfhp_pkg::ST_ERROR;
            n_phase  = PH_DONE;
        end
    end

    // result beat; lengths only shown once the header is complete
    always_comb begin
        n_out.status      = n_status;
        n_out.field_tag   = tag;
        n_out.string_byte = sbyte;
        if (n_status == bfhp_pkg::ST_DONE) begin
            n_out.header_length    = n_pos;
            n_out.bitstream_length = n_acc;
        end else begin
            n_out.header_length    = '0;
            n_out.bitstream_length = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_even_magic <= 8'h0f;
            r_odd_magic  <= 8'hf0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bfhp_pkg::REG_EVEN_MAGIC: r_even_magic <= i_cfg_data;
                bfhp_pkg::REG_ODD_MAGIC:  r_odd_magic  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_MLEN_HI;
            r_fcount    <= '0;
            r_flen      <= '0;
            r_pos       <= '0;
            r_acc       <= '0;
            r_status    <= bfhp_pkg::ST_PARSING;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase  <= n_phase;
                r_fcount <= n_fcount;
                r_flen   <= n_flen;
                r_pos    <= n_pos;
                r_acc    <= n_acc;
                r_status <= n_status;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_res_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

@@ test/bfhp_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfhp_tb_pkg
// Header parse model and result checking for the bit file header parser
// bench. Every accepted byte is parsed here and the beat it must produce is
// queued until the block delivers it.
// ----------------------------------------------------------------------------
package bfhp_tb_pkg;

    import bfhp_pkg::*;

    localparam logic [7:0]  KEY_FIRST       = "a";
    localparam logic [7:0]  KEY_LENGTH      = "e";
    localparam logic [15:0] MARKER_WORD     = 16'h0001;
    localparam logic [7:0]  STRING_END      = 8'h00;
    localparam logic [7:0]  EVEN_MAGIC_INIT = 8'h0f;
    localparam logic [7:0]  ODD_MAGIC_INIT  = 8'hf0;
    localparam int unsigned NUM_FIELDS      = 4;
    localparam int unsigned PRINT_CAP       = 40;

    typedef enum logic [3:0] {
        STEP_MLEN_HI,
        STEP_MLEN_LO,
        STEP_MAGIC,
        STEP_TERM,
        STEP_MARK_HI,
        STEP_MARK_LO,
        STEP_KEY,
        STEP_SLEN_HI,
        STEP_SLEN_LO,
        STEP_STRING,
        STEP_KEY_E,
        STEP_BITLEN,
        STEP_DONE
    } parse_step_e;

    class header_board;
        logic [7:0]  even_magic;
        logic [7:0]  odd_magic;
        parse_step_e step;
        int unsigned field;
        int unsigned seen;
        int unsigned str_len;
        int unsigned consumed;
        logic [7:0]  hi_byte;
        logic [31:0] bit_len;
        logic [1:0]  hdr_status;
        t_out_beat   parsed_results[$];
        int unsigned mismatches;

        function new();
            even_magic = EVEN_MAGIC_INIT;
            odd_magic  = ODD_MAGIC_INIT;
            mismatches = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            step       = STEP_MLEN_HI;
            field      = 0;
            seen       = 0;
            str_len    = 0;
            consumed   = 0;
            hi_byte    = '0;
            bit_len    = '0;
            hdr_status = ST_PARSING;
        endfunction

        function void abort_header();
            hdr_status = ST_ERROR;
            step       = STEP_DONE;
        endfunction

        function void set_magic(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
            if (idx == REG_EVEN_MAGIC)
                even_magic = value;
            else if (idx == REG_ODD_MAGIC)
                odd_magic = value;
        endfunction

        function int unsigned outstanding();
            return parsed_results.size();
        endfunction

        // parse one accepted byte and queue the beat it produces
        function void take_byte(t_in_beat beat);
            t_out_beat   res;
            logic [7:0]  b;
            logic [15:0] len16;
            res = '0;
            b   = beat.data_byte;
            if (beat.restart)
                clear_parse();
            if (hdr_status == ST_PARSING) begin
                if (consumed >= HEADER_LIMIT) begin
                    abort_header();
                end else begin
                    consumed++;
                    case (step)
                        STEP_MLEN_HI: begin
                            hi_byte = b;
                            step    = STEP_MLEN_LO;
                        end
                        STEP_MLEN_LO: begin
                            len16 = {hi_byte, b};
                            if (len16 == 16'd0) begin
                                abort_header();
                            end else if (len16 == 16'd1) begin
                                step = STEP_TERM;
                            end else begin
                                str_len = len16 - 16'd1;
                                seen    = 0;
                                step    = STEP_MAGIC;
                            end
                        end
                        STEP_MAGIC: begin
                            if (b != (seen[0] ? odd_magic : even_magic)) begin
                                abort_header();
                            end else begin
                                seen++;
                                if (seen >= str_len)
                                    step = STEP_TERM;
                            end
                        end
                        STEP_TERM: step = STEP_MARK_HI;
                        STEP_MARK_HI: begin
                            hi_byte = b;
                            step    = STEP_MARK_LO;
                        end
                        STEP_MARK_LO: begin
                            if ({hi_byte, b} != MARKER_WORD) begin
                                abort_header();
                            end else begin
                                field = 0;
                                step  = STEP_KEY;
                            end
                        end
                        STEP_KEY: begin
                            if (b != 8'(KEY_FIRST + field))
                                abort_header();
                            else
                                step = STEP_SLEN_HI;
                        end
                        STEP_SLEN_HI: begin
                            hi_byte = b;
                            step    = STEP_SLEN_LO;
                        end
                        STEP_SLEN_LO: begin
                            str_len = {hi_byte, b};
                            seen    = 0;
                            if (str_len == 0)
                                abort_header();
                            else
                                step = STEP_STRING;
                        end
                        STEP_STRING: begin
                            res.field_tag   = 3'(field + 1);
                            res.string_byte = b;
                            if (seen + 1 >= str_len) begin
                                if (b != STRING_END) begin
                                    abort_header();
                                end else if (field == NUM_FIELDS - 1) begin
                                    step = STEP_KEY_E;
                                end else begin
                                    field++;
                                    step = STEP_KEY;
                                end
                            end else begin
                                seen++;
                            end
                        end
                        STEP_KEY_E: begin
                            if (b != KEY_LENGTH) begin
                                abort_header();
                            end else begin
                                bit_len = '0;
                                seen    = 0;
                                step    = STEP_BITLEN;
                            end
                        end
                        STEP_BITLEN: begin
                            bit_len = {bit_len[23:0], b};
                            seen++;
                            if (seen >= 4) begin
                                hdr_status = ST_DONE;
                                step       = STEP_DONE;
                            end
                        end
                        default: abort_header();
                    endcase
                end
            end
            res.status = hdr_status;
            if (hdr_status == ST_DONE) begin
                res.header_length    = POS_W'(consumed);
                res.bitstream_length = bit_len;
            end
            parsed_results.push_back(res);
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("[%0t] mismatch: %s", $time, what);
        endtask

        task compare_result(t_out_beat got);
            t_out_beat want;
            if (parsed_results.size() == 0) begin
                report($sformatf("result beat %h with nothing pending", got));
                return;
            end
            want = parsed_results.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, wanted %0d", got.status, want.status));
            if (got.field_tag !== want.field_tag)
                report($sformatf("field tag %0d, wanted %0d", got.field_tag, want.field_tag));
            if (got.string_byte !== want.string_byte)
                report($sformatf("string byte %h, wanted %h",
                                 got.string_byte, want.string_byte));
            if (got.header_length !== want.header_length)
                report($sformatf("header length %0d, wanted %0d",
                                 got.header_length, want.header_length));
            if (got.bitstream_length !== want.bitstream_length)
                report($sformatf("bitstream length %h, wanted %h",
                                 got.bitstream_length, want.bitstream_length));
        endtask
    endclass

endpackage

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Bench for bit_file_header_parser_core. Directed headers hit the format's
// corner cases (magic length zero and one, bad magic, marker and keys, empty
// strings, unterminated strings, lengths with a nonzero high byte); then
// random well formed, damaged and truncated headers run under several magic
// settings. Every result beat is checked against the bench's own parse of
// the bytes.
// ----------------------------------------------------------------------------
module testbench;

    import bfhp_pkg::*;
    import bfhp_tb_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    // receiver behavior, picked anew at random when each run of it ends
    localparam int unsigned RX_FREE   = 0;
    localparam int unsigned RX_RANDOM = 1;
    localparam int unsigned RX_BURSTY = 2;

    // cycles without any beat moving before the run is declared hung
    localparam int unsigned STALL_LIMIT = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    bfhp_in_if  byte_ch ();
    bfhp_out_if res_ch ();

    bit_file_header_parser_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_ch  (byte_ch),
        .o_res_ch   (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    header_board board = new();

    // bytes waiting to be sent, with the restart flag of each
    t_in_beat byte_stream[$];

    // magic values currently loaded in the block
    logic [7:0] even_magic = EVEN_MAGIC_INIT;
    logic [7:0] odd_magic  = ODD_MAGIC_INIT;

    // ------------------------------------------------------------------------
    // header construction
    // ------------------------------------------------------------------------

    // full header with the current magic values; string bytes are random
    // with a zero last byte, and a zero length gives an empty string
    function automatic void build_header(input int unsigned mlen,
                                         input int unsigned slen [4],
                                         input logic [31:0] blen,
                                         output byte_q_t hdr);
        hdr.delete();
        hdr.push_back(8'(mlen >> 8));
        hdr.push_back(8'(mlen));
        for (int i = 1; i < mlen; i++)
            hdr.push_back((i % 2 == 1) ? even_magic : odd_magic);
        // terminator is never checked
        hdr.push_back(8'($urandom_range(0, 255)));
        hdr.push_back(MARKER_WORD[15:8]);
        hdr.push_back(MARKER_WORD[7:0]);
        for (int f = 0; f < NUM_FIELDS; f++) begin
            hdr.push_back(8'(KEY_FIRST + f));
            hdr.push_back(8'(slen[f] >> 8));
            hdr.push_back(8'(slen[f]));
            for (int j = 0; j < slen[f]; j++)
                hdr.push_back((j == slen[f] - 1) ? STRING_END : 8'($urandom_range(0, 255)));
        end
        hdr.push_back(KEY_LENGTH);
        for (int k = 3; k >= 0; k--)
            hdr.push_back(blen[8*k +: 8]);
    endfunction

    function automatic void queue_bytes(input byte_q_t hdr, input logic first_restart);
        t_in_beat beat;
        foreach (hdr[i]) begin
            beat.data_byte = hdr[i];
            beat.restart   = (i == 0) ? first_restart : 1'b0;
            byte_stream.push_back(beat);
        end
    endfunction

    function automatic logic [31:0] pick_bitstream_length();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // mostly well formed headers with random content, the rest damaged,
    // cut short or plain noise; ignored bytes are not counted
    function automatic void add_random_headers(input int unsigned byte_budget);
        byte_q_t     hdr;
        int unsigned slen [4];
        int unsigned made;
        int unsigned kind;
        int unsigned mlen;
        int unsigned pos;
        t_in_beat    beat;
        made = 0;
        while (made < byte_budget) begin
            kind = $urandom_range(0, 99);
            if (kind < 10) begin
                // noise, may or may not start a fresh parse
                repeat ($urandom_range(1, 6)) begin
                    beat.data_byte = 8'($urandom_range(0, 255));
                    beat.restart   = 1'($urandom_range(0, 1));
                    byte_stream.push_back(beat);
                end
            end else begin
                mlen = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40)
                                                    : $urandom_range(1, 8);
                foreach (slen[f])
                    slen[f] = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 24)
                                                           : $urandom_range(1, 8);
                build_header(mlen, slen, pick_bitstream_length(), hdr);
                if (kind >= 75) begin
                    pos = $urandom_range(0, hdr.size() - 1);
                    if ($urandom_range(0, 1) == 1) begin
                        hdr[pos] ^= 8'($urandom_range(1, 255));
                    end else begin
                        while (hdr.size() > pos + 1)
                            hdr.delete(hdr.size() - 1);
                    end
                end
                made += hdr.size();
                // now and then no restart, so the new bytes land on old state
                queue_bytes(hdr, $urandom_range(0, 19) != 0);
                if (kind % 5 == 0) begin
                    // trailing bytes after the header end are ignored
                    repeat ($urandom_range(1, 3)) begin
                        beat.data_byte = 8'($urandom_range(0, 255));
                        beat.restart   = 1'b0;
                        byte_stream.push_back(beat);
                    end
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // sender works in bursts of random length with random gaps
    task automatic send_stream();
        t_in_beat    cur;
        int unsigned burst;
        int unsigned gap;
        while (byte_stream.size() > 0) begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                : $urandom_range(1, 24);
            while (burst > 0 && byte_stream.size() > 0) begin
                cur = byte_stream.pop_front();
                byte_ch.valid <= 1'b1;
                byte_ch.data  <= cur;
                do @(posedge i_clk); while (!byte_ch.ready);
                board.take_byte(cur);
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        byte_ch.valid <= 1'b0;
    endtask

    // wait until every pending result has been delivered and checked
    task automatic wait_drained();
        while (board.outstanding() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_magic(idx, value);
        if (idx == REG_EVEN_MAGIC)
            even_magic = value;
        else
            odd_magic = value;
    endtask

    // ------------------------------------------------------------------------
    // result side: check every accepted beat, stall on a changing pattern
    // ------------------------------------------------------------------------
    int unsigned rx_mode = RX_FREE;
    int unsigned rx_left = 0;
    int unsigned rx_hold = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            board.compare_result(res_ch.data);
        if (rx_left == 0) begin
            rx_mode = $urandom_range(RX_FREE, RX_BURSTY);
            rx_left = $urandom_range(32, 256);
        end
        rx_left--;
        case (rx_mode)
            RX_FREE: begin
                res_ch.ready <= 1'b1;
            end
            RX_RANDOM: begin
                res_ch.ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                // long runs of ready and of stall
                if (rx_hold == 0) begin
                    rx_hold = $urandom_range(1, 12);
                    res_ch.ready <= !res_ch.ready;
                end else begin
                    rx_hold--;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        byte_q_t    hdr;
        logic [7:0] ev;
        logic [7:0] od;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_EVEN_MAGIC;
        i_cfg_data    = '0;
        byte_ch.valid = 1'b0;
        byte_ch.data  = '0;
        res_ch.ready  = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed headers, magic values as after reset ---

        // magic length one, single byte strings, first file without restart
        build_header(1, '{1, 1, 1, 1}, 32'h0000_0000, hdr);
        queue_bytes(hdr, 1'b0);
        // one magic byte, longest bitstream length, then ignored trailing bytes
        build_header(2, '{2, 3, 1, 4}, 32'hffff_ffff, hdr);
        hdr.push_back(8'hff);
        hdr.push_back(8'h00);
        queue_bytes(hdr, 1'b1);
        // zero magic length, the rest of the header is ignored
        build_header(0, '{1, 1, 1, 1}, 32'h1234_5678, hdr);
        queue_bytes(hdr, 1'b1);

        // fixed layout: magic length 3, strings of 2; byte 2 and 3 magic,
        // 5 and 6 marker, 7/12/17/22 keys a to d, 27 key e
        build_header(3, '{2, 2, 2, 2}, 32'h0102_0304, hdr);
        queue_bytes(hdr, 1'b1);
        build_header(3, '{2, 2, 2, 2}, 32'h8000_0001, hdr);
        hdr[2] ^= 8'h01;                  // bad even magic byte
        queue_bytes(hdr, 1'b1);
        build_header(3, '{2, 2, 2, 2}, 32'h8000_0001, hdr);
        hdr[3] ^= 8'h80;                  // bad odd magic byte
        queue_bytes(hdr, 1'b1);
        build_header(3, '{2, 2, 2, 2}, 32'h8000_0001, hdr);
        hdr[5] = 8'h01;                   // marker high byte set
        queue_bytes(hdr, 1'b1);
        build_header(3, '{2, 2, 2, 2}, 32'h8000_0001, hdr);
        hdr[6] = 8'h00;                   // marker low byte clear
        queue_bytes(hdr, 1'b1);
        build_header(3, '{2, 2, 2, 2}, 32'h8000_0001, hdr);
        hdr[7] = KEY_FIRST + 8'd1;        // key b where a belongs
        queue_bytes(hdr, 1'b1);
        build_header(3, '{2, 2, 2, 2}, 32'h8000_0001, hdr);
        hdr[22] = KEY_LENGTH;             // key e where d belongs
        queue_bytes(hdr, 1'b1);
        build_header(3, '{2, 2, 2, 2}, 32'h8000_0001, hdr);
        hdr[27] = KEY_LENGTH + 8'd1;      // wrong final key
        queue_bytes(hdr, 1'b1);
        build_header(3, '{2, 2, 2, 2}, 32'h8000_0001, hdr);
        hdr[16] = 8'hff;                  // part name not zero terminated
        queue_bytes(hdr, 1'b1);
        // empty part name
        build_header(3, '{2, 0, 2, 2}, 32'h8000_0001, hdr);
        queue_bytes(hdr, 1'b1);
        // header cut short, then restart in the middle of nowhere
        build_header(3, '{2, 2, 2, 2}, 32'h5555_aaaa, hdr);
        while (hdr.size() > 10)
            hdr.delete(hdr.size() - 1);
        queue_bytes(hdr, 1'b1);
        build_header(3, '{2, 2, 2, 2}, 32'haaaa_5555, hdr);
        queue_bytes(hdr, 1'b1);
        // lengths with a nonzero high byte
        build_header(16'h0102, '{16'h0100, 1, 1, 1}, 32'h0f0f_f0f0, hdr);
        queue_bytes(hdr, 1'b1);
        send_stream();

        // --- random headers under several magic settings ---
        for (int p = 0; p < 5; p++) begin
            wait_drained();
            case (p)
                0: begin
                    ev = 8'h00;
                    od = 8'hff;
                end
                1: begin
                    ev = 8'hff;
                    od = 8'h00;
                end
                2: begin
                    ev = 8'ha5;
                    od = 8'ha5;
                end
                default: begin
                    ev = 8'($urandom_range(0, 255));
                    od = 8'($urandom_range(0, 255));
                end
            endcase
            write_reg(REG_EVEN_MAGIC, ev);
            write_reg(REG_ODD_MAGIC, od);
            add_random_headers(80);
            send_stream();
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (board.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
